// File: hdl/mfdc_pkg.sv
// Shared types, constants and CRC function for the frame deframer.
package mfdc_pkg;

  localparam int unsigned LenBits = 16;

  localparam logic [7:0]  ChanCountRst   = 8'd3;
  localparam logic [7:0]  CanIdRst       = 8'd255;
  localparam logic [6:0]  CanBytesRst    = 7'd16;
  localparam logic [31:0] DelimRst       = 32'hC01D_BEEF;
  localparam logic [31:0] CrcInit        = 32'hFFFF_FFFF;
  localparam logic [31:0] CrcPoly        = 32'hEDB8_8320;

  localparam int unsigned CfgIdxBits = 8;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgChanCount = 8'd0,
    CfgCanId     = 8'd1,
    CfgCanBytes  = 8'd2,
    CfgDelim     = 8'd3
  } cfg_idx_e;

  typedef enum logic [6:0] {
    PhHunt  = 7'b0000001,
    PhId    = 7'b0000010,
    PhLenLo = 7'b0000100,
    PhLenHi = 7'b0001000,
    PhData  = 7'b0010000,
    PhChkLo = 7'b0100000,
    PhChkHi = 7'b1000000
  } phase_e;

  typedef enum logic [1:0] {
    RouteChan    = 2'd0,
    RouteCan     = 2'd1,
    RouteBadId   = 2'd2,
    RouteCanLong = 2'd3
  } route_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StMismatch = 2'd1,
    StUnknown  = 2'd2,
    StTooLong  = 2'd3
  } status_e;

  typedef enum logic {
    KindPayload = 1'b0,
    KindStatus  = 1'b1
  } kind_e;

  // Reflected CRC-32, one byte per call.
  function automatic logic [31:0] crc32_byte(logic [31:0] acc, logic [7:0] b);
    logic [31:0] c;
    c = acc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: hdl/mfdc_if.sv
// Valid/ready channel interfaces: received bytes, deframed results, register writes.
interface mfdc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mfdc_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic        to_can;
  logic [7:0]  channel;
  logic [7:0]  payload_byte;
  logic        last;
  logic [1:0]  status;
  logic [15:0] frame_length;
  logic [15:0] received_check;
  logic [15:0] computed_check;

  modport source (output valid, output kind, output to_can, output channel,
                  output payload_byte, output last, output status,
                  output frame_length, output received_check,
                  output computed_check, input ready);
  modport sink   (input valid, input kind, input to_can, input channel,
                  input payload_byte, input last, input status,
                  input frame_length, input received_check,
                  input computed_check, output ready);
endinterface

interface mfdc_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/mux_frame_deframer_crc.sv
// Deframer: delimiter hunt, header parse, payload routing and CRC-32 check.
// A result is registered and appears on out_if in the cycle after the byte that causes it.
// Throughput: one byte per cycle; in_if.ready drops only while a result sits
// in the output register and the sink stalls it.
// Reset: phase returns to delimiter hunt, CRC to all ones, registers to
// their defaults, output register empty. Config writes are always taken.
module mux_frame_deframer_crc (
  input  logic         clk_i,
  input  logic         rst_ni,
  mfdc_in_if.sink      in_if,
  mfdc_out_if.source   out_if,
  mfdc_cfg_if.sink     cfg_if
);
  import mfdc_pkg::*;

  // configuration
  logic [7:0]  chan_count_q, can_id_q;
  logic [6:0]  can_bytes_q;
  logic [31:0] delim_q;

  // frame state
  phase_e              phase_q, phase_d;
  logic [1:0]          match_q, match_d;
  logic [7:0]          chan_q, chan_d;
  logic [LenBits-1:0]  len_q, len_d;
  logic [LenBits-1:0]  left_q, left_d;
  logic [31:0]         crc_q, crc_d;
  logic [7:0]          chk_lo_q, chk_lo_d;
  route_e              route_q, route_d;

  // result register
  logic        out_valid_q;
  logic        kind_q, to_can_q, last_q;
  logic [7:0]  chan_out_q, pbyte_q;
  logic [1:0]  status_q;
  logic [15:0] flen_q, rcv_q, cmp_q;

  logic        in_fire;
  logic [7:0]  b;
  logic [7:0]  delim_cur, delim_first;
  logic [2:0]  match_inc;
  logic [LenBits-1:0] len_full;
  logic [15:0] rcv, cmp;
  logic        emit;
  kind_e       res_kind;
  logic        res_last;
  logic [7:0]  res_pbyte;
  status_e     res_status;
  logic [15:0] res_rcv, res_cmp;

  assign in_if.ready  = !out_valid_q || out_if.ready;
  assign cfg_if.ready = 1'b1;
  assign in_fire      = in_if.valid && in_if.ready;
  assign b            = in_if.rx_byte;

  assign delim_first = delim_q[31:24];
  always_comb begin
    case (match_q)
      2'd0:    delim_cur = delim_q[31:24];
      2'd1:    delim_cur = delim_q[23:16];
      2'd2:    delim_cur = delim_q[15:8];
      default: delim_cur = delim_q[7:0];
    endcase
  end
  assign match_inc = {1'b0, match_q} + 3'd1;
  assign len_full  = LenBits'({b, len_q[7:0]});
  assign rcv       = {b, chk_lo_q};
  assign cmp       = ~crc_q[15:0];

  always_comb begin
    phase_d    = phase_q;
    match_d    = match_q;
    chan_d     = chan_q;
    len_d      = len_q;
    left_d     = left_q;
    crc_d      = crc_q;
    chk_lo_d   = chk_lo_q;
    route_d    = route_q;
    emit       = 1'b0;
    res_kind   = KindPayload;
    res_last   = 1'b0;
    res_pbyte  = 8'd0;
    res_status = StOk;
    res_rcv    = 16'd0;
    res_cmp    = 16'd0;
    if (in_fire) begin
      case (phase_q)
        PhHunt: begin
          if (b == delim_cur) begin
            if (match_inc == 3'd4) begin
              match_d = 2'd0;
              phase_d = PhId;
            end else begin
              match_d = match_inc[1:0];
            end
          end else if (b == delim_first) begin
            // broken match restarts on the first delimiter byte
            match_d = 2'd1;
          end else begin
            match_d = 2'd0;
          end
        end
        PhId: begin
          chan_d  = b;
          phase_d = PhLenLo;
        end
        PhLenLo: begin
          len_d   = LenBits'(b);
          phase_d = PhLenHi;
        end
        PhLenHi: begin
          len_d  = len_full;
          left_d = len_full;
          crc_d  = CrcInit;
          if (chan_q == can_id_q) begin
            route_d = (len_full <= LenBits'(can_bytes_q)) ? RouteCan : RouteCanLong;
          end else if (chan_q < chan_count_q) begin
            route_d = RouteChan;
          end else begin
            route_d = RouteBadId;
          end
          phase_d = (len_full == '0) ? PhChkLo : PhData;
        end
        PhData: begin
          crc_d  = crc32_byte(crc_q, b);
          left_d = left_q - LenBits'(1);
          if (left_q == LenBits'(1)) begin
            phase_d = PhChkLo;
          end
          emit      = (route_q == RouteChan) || (route_q == RouteCan);
          res_pbyte = b;
          res_last  = (left_q == LenBits'(1));
        end
        PhChkLo: begin
          chk_lo_d = b;
          phase_d  = PhChkHi;
        end
        PhChkHi: begin
          emit     = 1'b1;
          res_kind = KindStatus;
          res_rcv  = rcv;
          res_cmp  = cmp;
          case (route_q)
            RouteBadId:   res_status = StUnknown;
            RouteCanLong: res_status = StTooLong;
            default:      res_status = (rcv != cmp) ? StMismatch : StOk;
          endcase
          phase_d = PhHunt;
          match_d = 2'd0;
        end
        default: begin
          phase_d = PhHunt;
          match_d = 2'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_count_q <= ChanCountRst;
      can_id_q     <= CanIdRst;
      can_bytes_q  <= CanBytesRst;
      delim_q      <= DelimRst;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        CfgChanCount: chan_count_q <= cfg_if.data[7:0];
        CfgCanId:     can_id_q     <= cfg_if.data[7:0];
        CfgCanBytes:  can_bytes_q  <= cfg_if.data[6:0];
        CfgDelim:     delim_q      <= cfg_if.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhHunt;
      match_q  <= 2'd0;
      chan_q   <= 8'd0;
      len_q    <= '0;
      left_q   <= '0;
      crc_q    <= CrcInit;
      chk_lo_q <= 8'd0;
      route_q  <= RouteChan;
    end else begin
      phase_q  <= phase_d;
      match_q  <= match_d;
      chan_q   <= chan_d;
      len_q    <= len_d;
      left_q   <= left_d;
      crc_q    <= crc_d;
      chk_lo_q <= chk_lo_d;
      route_q  <= route_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= emit;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && emit) begin
      kind_q     <= res_kind;
      to_can_q   <= (route_q == RouteCan);
      chan_out_q <= chan_q;
      pbyte_q    <= res_pbyte;
      last_q     <= res_last;
      status_q   <= res_status;
      flen_q     <= 16'(len_q);
      rcv_q      <= res_rcv;
      cmp_q      <= res_cmp;
    end
  end

  assign out_if.valid          = out_valid_q;
  assign out_if.kind           = kind_q;
  assign out_if.to_can         = to_can_q;
  assign out_if.channel        = chan_out_q;
  assign out_if.payload_byte   = pbyte_q;
  assign out_if.last           = last_q;
  assign out_if.status         = status_q;
  assign out_if.frame_length   = flen_q;
  assign out_if.received_check = rcv_q;
  assign out_if.computed_check = cmp_q;

endmodule

// File: hdl/mfdc_checker.sv
// Port-level checks on the deframer result channel, bound to the top level.
module mfdc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        kind_i,
  input logic        to_can_i,
  input logic [7:0]  payload_byte_i,
  input logic        last_i,
  input logic [1:0]  status_i,
  input logic [15:0] received_check_i,
  input logic [15:0] computed_check_i
);
  import mfdc_pkg::*;

  // a stalled beat stays put
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i)
      && $stable(payload_byte_i) && $stable(kind_i))
    else $error("result beat changed while stalled");

  a_status_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i == KindStatus |-> !last_i && payload_byte_i == 8'd0)
    else $error("status beat carries payload fields");

  a_payload_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i == KindPayload |->
      status_i == StOk && received_check_i == 16'd0 && computed_check_i == 16'd0)
    else $error("payload beat carries status fields");

  a_ok_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i == KindStatus && status_i == StOk |->
      received_check_i == computed_check_i)
    else $error("ok status with mismatching check");

  a_route_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == StUnknown || status_i == StTooLong) |->
      kind_i == KindStatus && !to_can_i)
    else $error("route error on a routed beat");

endmodule

bind mux_frame_deframer_crc mfdc_checker u_mfdc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_if.valid),
  .out_ready_i      (out_if.ready),
  .kind_i           (out_if.kind),
  .to_can_i         (out_if.to_can),
  .payload_byte_i   (out_if.payload_byte),
  .last_i           (out_if.last),
  .status_i         (out_if.status),
  .received_check_i (out_if.received_check),
  .computed_check_i (out_if.computed_check)
);

// File: dv/tb.sv
// Testbench for the frame deframer: random framed byte streams checked against a local predictor.
module tb;
  import mfdc_pkg::*;

  localparam logic [31:0] Crc32Poly  = 32'hEDB8_8320;
  localparam int unsigned HoldCycles = 80;
  localparam int unsigned StuckLimit = 1000;

  typedef struct packed {
    logic        kind;
    logic        to_can;
    logic [7:0]  channel;
    logic [7:0]  payload_byte;
    logic        last;
    logic [1:0]  status;
    logic [15:0] frame_length;
    logic [15:0] received_check;
    logic [15:0] computed_check;
  } beat_t;

  logic clk_i = 1'b1;
  logic rst_ni;

  mfdc_in_if  in_if ();
  mfdc_out_if out_if ();
  mfdc_cfg_if cfg_if ();

  mux_frame_deframer_crc dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  always begin
    #10 clk_i = 1'b0;
    #10 clk_i = 1'b1;
  end

  // register copies seen by the predictor and the frame builder
  logic [7:0]  cf_chan_count = 8'd3;
  logic [7:0]  cf_can_id     = 8'd255;
  logic [6:0]  cf_can_bytes  = 7'd16;
  logic [31:0] cf_delim      = 32'hC01D_BEEF;

  // predictor state
  phase_e      ph     = PhHunt;
  logic [2:0]  mcount = 3'd0;
  logic [7:0]  fchan  = 8'd0;
  logic [15:0] flen   = 16'd0;
  logic [15:0] left   = 16'd0;
  logic [31:0] crc    = 32'hFFFF_FFFF;
  logic [7:0]  chk_lo = 8'd0;
  route_e      route  = RouteChan;

  logic [7:0] rx_pending[$];
  beat_t      due_beats[$];

  int unsigned n_queued, n_rx, n_payload, n_status, n_err, n_settings, stuck;
  bit          in_took, out_took, hold_req;
  int unsigned in_gap, in_calm, out_gap, out_calm, hold_left;

  function automatic logic [7:0] delim_at(int unsigned k);
    return cf_delim[(31 - 8 * k) -: 8];
  endfunction

  function automatic logic [31:0] crc_step(logic [31:0] c, logic [7:0] d);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ d[i];
      c  = c >> 1;
      if (fb) c = c ^ Crc32Poly;
    end
    return c;
  endfunction

  task automatic queue_beat(logic kind, logic [7:0] pbyte, logic lst, logic [1:0] st,
                            logic [15:0] rcv, logic [15:0] cmp);
    beat_t e;
    e.kind           = kind;
    e.to_can         = (route == RouteCan);
    e.channel        = fchan;
    e.payload_byte   = pbyte;
    e.last           = lst;
    e.status         = st;
    e.frame_length   = flen;
    e.received_check = rcv;
    e.computed_check = cmp;
    due_beats = {due_beats, e};
  endtask

  task automatic deframe_byte(logic [7:0] b);
    logic [15:0] rcv;
    logic [15:0] cmp;
    logic [1:0]  st;
    case (ph)
      PhHunt: begin
        // a byte that breaks the match but equals the first delimiter byte restarts it
        if (b == delim_at(mcount)) mcount = mcount + 3'd1;
        else if (b == delim_at(0)) mcount = 3'd1;
        else mcount = 3'd0;
        if (mcount == 3'd4) begin
          mcount = 3'd0;
          ph     = PhId;
        end
      end
      PhId: begin
        fchan = b;
        ph    = PhLenLo;
      end
      PhLenLo: begin
        flen = {8'd0, b};
        ph   = PhLenHi;
      end
      PhLenHi: begin
        flen = {b, flen[7:0]};
        left = flen;
        crc  = 32'hFFFF_FFFF;
        // CAN id wins over a numbered channel
        if (fchan == cf_can_id) route = (flen <= {9'd0, cf_can_bytes}) ? RouteCan : RouteCanLong;
        else if (fchan < cf_chan_count) route = RouteChan;
        else route = RouteBadId;
        ph = (flen == 16'd0) ? PhChkLo : PhData;
      end
      PhData: begin
        crc  = crc_step(crc, b);
        left = left - 16'd1;
        if (left == 16'd0) ph = PhChkLo;
        if (route == RouteChan || route == RouteCan) begin
          queue_beat(KindPayload, b, left == 16'd0, StOk, 16'd0, 16'd0);
        end
      end
      PhChkLo: begin
        chk_lo = b;
        ph     = PhChkHi;
      end
      PhChkHi: begin
        rcv = {b, chk_lo};
        cmp = ~crc[15:0];
        case (route)
          RouteBadId:   st = StUnknown;
          RouteCanLong: st = StTooLong;
          default:      st = (rcv != cmp) ? StMismatch : StOk;
        endcase
        queue_beat(KindStatus, 8'd0, 1'b0, st, rcv, cmp);
        ph     = PhHunt;
        mcount = 3'd0;
      end
      default: begin
        ph     = PhHunt;
        mcount = 3'd0;
      end
    endcase
  endtask

  task automatic apply_reg(logic [7:0] idx, logic [31:0] data);
    case (cfg_idx_e'(idx))
      CfgChanCount: cf_chan_count = data[7:0];
      CfgCanId:     cf_can_id     = data[7:0];
      CfgCanBytes:  cf_can_bytes  = data[6:0];
      CfgDelim:     cf_delim      = data;
      default: ;
    endcase
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      n_err++;
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  task automatic draw_wait(inout int unsigned calm, output int unsigned gap);
    if (calm > 0) begin
      calm--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 7);
      if ($urandom_range(0, 29) == 0) calm = $urandom_range(20, 60);
    end
  endtask

  // output check first, then prediction: a byte's result shows up in the cycle after
  always @(posedge clk_i) begin : beat_monitor
    beat_t seen;
    beat_t want;
    bit    moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (out_if.valid && out_if.ready) begin
        moved                = 1'b1;
        out_took             = 1'b1;
        seen.kind            = out_if.kind;
        seen.to_can          = out_if.to_can;
        seen.channel         = out_if.channel;
        seen.payload_byte    = out_if.payload_byte;
        seen.last            = out_if.last;
        seen.status          = out_if.status;
        seen.frame_length    = out_if.frame_length;
        seen.received_check  = out_if.received_check;
        seen.computed_check  = out_if.computed_check;
        if (seen.kind == KindStatus) n_status++;
        else n_payload++;
        if (due_beats.size() == 0) begin
          n_err++;
          $display("%0t: expected no beat, got kind %0d channel %0h byte %0h status %0d",
                   $time, seen.kind, seen.channel, seen.payload_byte, seen.status);
        end else begin
          want = due_beats.pop_front();
          check_field("kind", 16'(want.kind), 16'(seen.kind));
          check_field("to_can", 16'(want.to_can), 16'(seen.to_can));
          check_field("channel", 16'(want.channel), 16'(seen.channel));
          check_field("payload_byte", 16'(want.payload_byte), 16'(seen.payload_byte));
          check_field("last", 16'(want.last), 16'(seen.last));
          check_field("status", 16'(want.status), 16'(seen.status));
          check_field("frame_length", want.frame_length, seen.frame_length);
          check_field("received_check", want.received_check, seen.received_check);
          check_field("computed_check", want.computed_check, seen.computed_check);
        end
      end
      if (in_if.valid && in_if.ready) begin
        moved   = 1'b1;
        in_took = 1'b1;
        n_rx++;
        deframe_byte(in_if.rx_byte);
      end
      if (cfg_if.valid && cfg_if.ready) begin
        moved = 1'b1;
        apply_reg(cfg_if.index, cfg_if.data);
      end
      if (!moved && (n_rx != n_queued || due_beats.size() != 0)) stuck++;
      else stuck = 0;
      if (stuck >= StuckLimit) begin
        $display("%0t: no beat moved for %0d cycles", $time, stuck);
        $display("mux_frame_deframer_crc: mismatch");
        $finish;
      end
    end
  end

  always @(negedge clk_i) begin : rx_driver
    bit slot_open;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      slot_open = !in_if.valid || in_took;
      if (in_took) begin
        in_took = 1'b0;
        draw_wait(in_calm, in_gap);
      end
      if (slot_open) begin
        if (in_gap > 0) begin
          in_gap--;
          in_if.valid <= 1'b0;
        end else if (rx_pending.size() > 0) begin
          in_if.valid   <= 1'b1;
          in_if.rx_byte <= rx_pending.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(negedge clk_i) begin : tx_sink
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
      end
      if (out_took) begin
        out_took = 1'b0;
        draw_wait(out_calm, out_gap);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  task automatic put(logic [7:0] b);
    rx_pending = {rx_pending, b};
    n_queued++;
  endtask

  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == delim_at(0) || b == delim_at(1) || b == delim_at(2) || b == delim_at(3));
    return b;
  endfunction

  task automatic push_frame(logic [7:0] chan, logic [15:0] ln, bit good, int fill = -1);
    logic [31:0] c;
    logic [7:0]  d;
    logic [15:0] chk;
    for (int k = 0; k < 4; k++) put(delim_at(k));
    put(chan);
    put(ln[7:0]);
    put(ln[15:8]);
    c = 32'hFFFF_FFFF;
    for (int i = 0; i < ln; i++) begin
      d = (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);
      c = crc_step(c, d);
      put(d);
    end
    chk = ~c[15:0];
    if (!good) chk = chk ^ 16'($urandom_range(1, 65535));
    put(chk[7:0]);
    put(chk[15:8]);
  endtask

  // mostly whole frames; some noise and cut-off delimiters in between
  task automatic random_traffic(int unsigned nbytes);
    int unsigned stop, pick, k;
    logic [7:0]  chan;
    logic [15:0] ln;
    bit          head_unique;
    stop = n_queued + nbytes;
    while (n_queued < stop) begin
      head_unique = delim_at(0) != delim_at(1) && delim_at(0) != delim_at(2) &&
                    delim_at(0) != delim_at(3);
      pick = $urandom_range(0, 9);
      if (pick < 2) begin
        repeat ($urandom_range(1, 3)) put(noise_byte());
      end else if (pick < 4) begin
        k = $urandom_range(1, 3);
        for (int i = 0; i < k; i++) put(delim_at(i));
        // a direct restart only lines up when the first byte does not recur
        if (!(head_unique && $urandom_range(0, 1))) put(noise_byte());
      end
      pick = $urandom_range(0, 9);
      if (pick < 4 && cf_chan_count != 0) chan = 8'($urandom_range(0, cf_chan_count - 1));
      else if (pick < 7) chan = cf_can_id;
      else chan = 8'($urandom_range(0, 255));
      if (chan == cf_can_id) ln = 16'($urandom_range(0, cf_can_bytes + 3));
      else if ($urandom_range(0, 3) != 0) ln = 16'($urandom_range(0, 16));
      else ln = 16'($urandom_range(17, 48));
      push_frame(chan, ln, $urandom_range(0, 9) != 0);
    end
  endtask

  task automatic set_reg(cfg_idx_e idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (n_rx != n_queued || due_beats.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    n_settings++;
  endtask

  initial begin : stimulus
    in_if.valid   = 1'b0;
    in_if.rx_byte = 8'd0;
    out_if.ready  = 1'b0;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = 8'd0;
    cfg_if.data   = 32'd0;
    rst_ni        = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: extremes, restarts, every status
    put(8'h00);
    put(8'hFF);
    put(delim_at(0));
    put(delim_at(1));
    push_frame(8'd0, 16'd0, 1'b1);          // restart after two bytes, empty frame
    put(delim_at(0));
    push_frame(8'd2, 16'd2, 1'b1, 8'h00);   // restart on a repeated first byte
    push_frame(8'd1, 16'd2, 1'b1, 8'hFF);
    push_frame(8'd255, 16'd16, 1'b1);       // largest CAN frame
    push_frame(8'd255, 16'd17, 1'b1);       // CAN frame one byte too long
    push_frame(8'd255, 16'd0, 1'b1);
    push_frame(8'd3, 16'd1, 1'b1);          // first id past the channel count
    push_frame(8'd0, 16'd4, 1'b0);          // bad check
    wait_drained();

    set_reg(CfgChanCount, 32'd254);
    set_reg(CfgCanId, 32'd0);
    set_reg(CfgCanBytes, 32'd64);
    set_reg(CfgDelim, $urandom);
    hold_req = 1'b1;
    push_frame(8'd253, 16'd258, 1'b1);      // length high byte in use
    random_traffic(100);
    wait_drained();

    // no numbered channels, CAN only when empty; upper write bits must be dropped
    set_reg(CfgChanCount, 32'd0);
    set_reg(CfgCanBytes, 32'hFFFF_FF80);
    set_reg(CfgDelim, 32'h0000_0000);
    random_traffic(80);
    wait_drained();

    // CAN id also below the channel count
    set_reg(CfgChanCount, 32'd3);
    set_reg(CfgCanId, 32'd1);
    set_reg(CfgCanBytes, 32'd127);
    set_reg(CfgDelim, 32'hFFFF_FFFF);
    push_frame(8'd1, 16'd5, 1'b1);
    random_traffic(80);
    wait_drained();

    set_reg(CfgChanCount, 32'd255);
    set_reg(CfgCanId, $urandom_range(0, 255));
    set_reg(CfgCanBytes, $urandom_range(1, 64));
    set_reg(CfgDelim, $urandom);
    random_traffic(80);
    wait_drained();

    $display("%0d bytes deframed under %0d register settings with random stalls and a long hold",
             n_rx, n_settings);
    $display("%0d payload beats and %0d frame status beats checked", n_payload, n_status);
    if (n_err == 0 && due_beats.size() == 0) begin
      $display("mux_frame_deframer_crc: match");
    end else begin
      $display("mux_frame_deframer_crc: mismatch");
    end
    $finish;
  end

endmodule
